FILE: src/crlss_pkg.sv
// Package for the cable rest-length slew servo.
// Holds payload structs, register indexes, state enum and command/status structs.
// No dependencies.
`timescale 1ns / 1ps
package crlss_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_TARGET_VELOCITY  = 3'd0;
    localparam logic [2:0] REG_MAX_ACCELERATION = 3'd1;
    localparam logic [2:0] REG_MAX_TENSION      = 3'd2;
    localparam logic [2:0] REG_MIN_CABLE_LENGTH = 3'd3;
    localparam logic [2:0] REG_MIN_REST_LENGTH  = 3'd4;
    localparam logic [2:0] REG_STIFFNESS        = 3'd5;
    localparam logic [2:0] REG_TIME_STEP        = 3'd6;

    // Mode codes.
    localparam logic [1:0] MODE_SLEW    = 2'd0;
    localparam logic [1:0] MODE_TENSION = 2'd1;
    localparam logic [1:0] MODE_DIRECT  = 2'd2;

    localparam int DIV_W = 64;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] command_value;
        logic [30:0]        measured_length;
        logic signed [31:0] measured_tension;
        logic signed [31:0] last_velocity;
    } in_beat_t;

    typedef struct packed {
        logic [30:0]        new_rest_length;
        logic signed [31:0] new_preferred_length;
        logic               status;
        logic               tension_capped;
        logic               accel_capped;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL1,
        ST_MUL2,
        ST_TDIV,
        ST_TDIV_W,
        ST_TCAP,
        ST_CDIV,
        ST_CDIV_W,
        ST_PREP,
        ST_RDIV,
        ST_RDIV_W,
        ST_FIN,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic tdiv_start;
        logic tdiv_take;
        logic tcap;
        logic cdiv_start;
        logic cdiv_take;
        logic prep;
        logic rdiv_start;
        logic fin;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic need_rdiv;
        logic is_tension;
        logic is_slew;
    } dp_stat_t;

endpackage

FILE: src/crlss_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on crlss_pkg.
`timescale 1ns / 1ps
module crlss_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [crlss_pkg::DIV_W-1:0]  dividend,
    input  logic [31:0]                         divisor,
    output logic                                done,
    output logic signed [crlss_pkg::DIV_W-1:0]  quotient
);
    import crlss_pkg::*;

    logic [DIV_W-1:0] q_reg, q_next;
    logic [32:0]      r_reg, r_next;
    logic [31:0]      d_reg, d_next;
    logic             neg_reg, neg_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [33:0]      trial;

    // Restoring shift-subtract step on the magnitude.
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            q_next    = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
            neg_next  = dividend[DIV_W-1];
            d_next    = divisor;
            r_next    = '0;
            cnt_next  = 7'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg, q_reg[DIV_W-1]} - {2'b00, d_reg};
            if (!trial[33])
            begin
                r_next = trial[32:0];
                q_next = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[31:0], q_reg[DIV_W-1]};
                q_next = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg)
                begin
                    q_next = DIV_W'(-q_next);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

FILE: src/crlss_ctrl.sv
// Controller state machine sequencing one tick through the datapath.
// Depends on crlss_pkg.
`timescale 1ns / 1ps
module crlss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output crlss_pkg::dp_cmd_t   cmd,
    input  crlss_pkg::dp_stat_t  stat
);
    import crlss_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:
            begin
                if (stat.is_tension)   state_next = ST_TDIV;
                else if (stat.is_slew) state_next = ST_CDIV;
                else                   state_next = ST_FIN;
            end
            ST_TDIV:   state_next = ST_TDIV_W;
            ST_TDIV_W: if (stat.div_done) state_next = ST_TCAP;
            ST_TCAP:   state_next = ST_CDIV;
            ST_CDIV:   state_next = ST_CDIV_W;
            ST_CDIV_W: if (stat.div_done) state_next = ST_PREP;
            ST_PREP:   state_next = stat.need_rdiv ? ST_RDIV : ST_FIN;
            ST_RDIV:   state_next = ST_RDIV_W;
            ST_RDIV_W: if (stat.div_done) state_next = ST_FIN;
            ST_FIN:    state_next = ST_OUT;
            ST_OUT:    if (!out_stall) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd            = '0;
        in_stall       = (state_reg != ST_IDLE);
        out_valid      = (state_reg == ST_OUT);
        cmd.load       = (state_reg == ST_IDLE) && in_valid;
        cmd.mul1       = (state_reg == ST_LOAD);
        cmd.mul2       = (state_reg == ST_MUL1);
        cmd.tdiv_start = (state_reg == ST_TDIV);
        cmd.tdiv_take  = (state_reg == ST_TDIV_W) && stat.div_done;
        cmd.tcap       = (state_reg == ST_TCAP);
        cmd.cdiv_start = (state_reg == ST_CDIV);
        cmd.cdiv_take  = (state_reg == ST_CDIV_W) && stat.div_done;
        cmd.prep       = (state_reg == ST_PREP);
        cmd.rdiv_start = (state_reg == ST_RDIV);
        cmd.fin        = (state_reg == ST_FIN);
    end
endmodule

FILE: src/crlss_dp.sv
// Datapath: config registers, lengths, products, shared divider and result register.
// Depends on crlss_pkg and crlss_div.
`timescale 1ns / 1ps
module crlss_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [30:0]           cfg_data,
    input  crlss_pkg::in_beat_t   in_data,
    input  crlss_pkg::dp_cmd_t    cmd,
    output crlss_pkg::dp_stat_t   stat,
    output crlss_pkg::out_beat_t  out_data
);
    import crlss_pkg::*;

    // Configuration registers.
    logic [30:0] tv_reg, acc_reg, tmax_reg, mincab_reg, minrest_reg, k_reg;
    logic [15:0] dt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg      <= '0;
            acc_reg     <= '0;
            tmax_reg    <= 31'h7FFF_FFFF;
            mincab_reg  <= '0;
            minrest_reg <= '0;
            k_reg       <= 31'd65536;
            dt_reg      <= 16'd655;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TARGET_VELOCITY:  tv_reg      <= cfg_data;
                REG_MAX_ACCELERATION: acc_reg     <= cfg_data;
                REG_MAX_TENSION:      tmax_reg    <= cfg_data;
                REG_MIN_CABLE_LENGTH: mincab_reg  <= cfg_data;
                REG_MIN_REST_LENGTH:  minrest_reg <= cfg_data;
                REG_STIFFNESS:        k_reg       <= cfg_data;
                REG_TIME_STEP:        dt_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [15:0] dt_eff;
    logic [30:0] k_eff;
    assign dt_eff = (dt_reg == '0) ? 16'd1 : dt_reg;
    assign k_eff  = (k_reg == '0) ? 31'd1 : k_reg;

    // Persistent lengths.
    logic signed [33:0] rest_reg, pref_reg;

    // Per-tick working registers.
    in_beat_t           in_reg;
    logic signed [33:0] step_reg, vchg_reg, capstep_reg, diff_reg;
    logic               tcap_reg, acap_reg, status_reg, upd_reg;
    logic               slewing_reg;
    out_beat_t          out_reg;

    logic is_tension, is_slew, cmd_ok;
    assign cmd_ok     = !in_reg.command_value[31];
    assign is_tension = (in_reg.mode == MODE_TENSION);
    assign is_slew    = (in_reg.mode == MODE_SLEW) && cmd_ok;

    // Shared divider.
    logic                    div_start, div_done;
    logic signed [DIV_W-1:0] div_num, div_q;
    logic [31:0]             div_den;
    logic signed [DIV_W-1:0] num_reg;
    logic [31:0]             den_reg;

    crlss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    assign div_start = cmd.tdiv_start || cmd.cdiv_start || cmd.rdiv_start;
    assign div_num   = num_reg;
    assign div_den   = den_reg;

    // Products, each registered.
    logic [46:0] p_step, p_vchg, p_cap;
    assign p_step = tv_reg * dt_eff;
    assign p_vchg = acc_reg * dt_eff;
    assign p_cap  = vchg_reg[30:0] * dt_eff;

    // Tension check: (meas - pref) * k > tmax * 65536.
    logic signed [33:0] meas_s, lv_s;
    logic signed [34:0] md;
    logic signed [66:0] tprod;
    logic signed [66:0] tlim;
    assign meas_s = 34'(in_reg.measured_length);
    assign lv_s   = 34'(in_reg.last_velocity);
    assign md     = 35'(meas_s) - 35'(pref_reg);
    assign tprod  = 67'(md) * $signed({36'd0, k_eff});
    assign tlim   = $signed({20'd0, tmax_reg, 16'd0});
    logic tcap_hit_reg;

    // Slew decision logic on current pref/rest.
    logic signed [34:0] diff_c, adiff;
    logic signed [34:0] tvs, vd, avd;
    logic               s_neg, allow, big, vfire;
    assign diff_c = 35'(pref_reg) - 35'(rest_reg);
    assign s_neg  = diff_c < 0;
    assign adiff  = s_neg ? -diff_c : diff_c;
    assign allow  = (in_reg.measured_length > mincab_reg) || (diff_c > 0);
    assign big    = adiff > 35'(step_reg);
    assign tvs    = s_neg ? -35'(tv_reg) : 35'(tv_reg);
    assign vd     = tvs - 35'(lv_s);
    assign avd    = vd < 0 ? -vd : vd;
    assign vfire  = avd > 35'(vchg_reg);

    // Rate compare with divider result.
    logic signed [DIV_W-1:0] rd, ard;
    logic                    rfire;
    assign rd    = div_q - DIV_W'(lv_s);
    assign ard   = rd < 0 ? -rd : rd;
    assign rfire = ard > DIV_W'(vchg_reg);

    function automatic logic signed [33:0] sat32f(input logic signed [DIV_W-1:0] x);
        if (x > 64'sh7FFF_FFFF)
            sat32f = 34'sh7FFF_FFFF;
        else if (x < -64'sh8000_0000)
            sat32f = -34'sh8000_0000;
        else
            sat32f = x[33:0];
    endfunction

    logic signed [DIV_W-1:0] nl;
    logic signed [34:0]      rnew;
    assign nl = DIV_W'(rest_reg) - div_q;

    // Final rest update and clamps.
    always_comb
    begin
        rnew = 35'(rest_reg);
        if (upd_reg)
        begin
            rnew = 35'(rest_reg) + 35'(diff_reg);
        end
        if (rnew < $signed(35'(minrest_reg)))
            rnew = $signed(35'(minrest_reg));
        if (rnew > 35'sh7FFF_FFFF)
            rnew = 35'sh7FFF_FFFF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg <= '0;
            pref_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (in_data.mode == MODE_SLEW && !in_data.command_value[31])
                    pref_reg <= 34'(in_data.command_value);
                if (in_data.mode == MODE_DIRECT && !in_data.command_value[31])
                begin
                    pref_reg <= 34'(in_data.command_value);
                    rest_reg <= 34'(in_data.command_value);
                end
            end
            if (cmd.tdiv_take)
            begin
                if (nl < $signed(DIV_W'(minrest_reg)))
                    pref_reg <= 34'(minrest_reg);
                else
                    pref_reg <= sat32f(nl);
            end
            if (cmd.cdiv_take && tcap_hit_reg)
                pref_reg <= sat32f(DIV_W'(meas_s) - div_q);
            if (cmd.fin && slewing_reg)
                rest_reg <= 34'(rnew);
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg   <= in_data;
            tcap_reg <= 1'b0;
            acap_reg <= 1'b0;
            upd_reg  <= 1'b0;
            status_reg <= (in_data.mode == MODE_SLEW || in_data.mode == MODE_DIRECT)
                          && in_data.command_value[31];
            slewing_reg <= (in_data.mode == MODE_TENSION) ||
                           (in_data.mode == MODE_SLEW && !in_data.command_value[31]);
            num_reg <= DIV_W'(35'($signed(in_data.command_value)) -
                       35'($signed(in_data.measured_tension))) <<< 16;
            den_reg <= {1'b0, k_eff};
        end
        if (cmd.mul1)
        begin
            step_reg <= 34'(p_step[46:16]);
            vchg_reg <= 34'(p_vchg[46:16]);
        end
        if (cmd.mul2)
        begin
            capstep_reg <= 34'(p_cap[46:16]);
        end
        if (cmd.tcap || (cmd.mul2 && !is_tension))
        begin
            // Tension cap check after preferred length is settled.
            tcap_hit_reg <= 1'b0;
            num_reg      <= DIV_W'({tmax_reg, 16'd0});
            den_reg      <= {1'b0, k_eff};
        end
        if (cmd.cdiv_start)
        begin
            tcap_hit_reg <= tprod > tlim;
            if (tprod > tlim)
                tcap_reg <= 1'b1;
        end
        if (cmd.prep)
        begin
            upd_reg  <= allow;
            if (allow && big)
            begin
                if (vfire)
                begin
                    acap_reg <= 1'b1;
                    diff_reg <= s_neg ? -capstep_reg : capstep_reg;
                end
                else
                begin
                    diff_reg <= s_neg ? -step_reg : step_reg;
                end
            end
            else
            begin
                diff_reg <= diff_c[33:0];
            end
            num_reg <= DIV_W'(diff_c) <<< 16;
            den_reg <= {16'd0, dt_eff};
        end
        if (cmd.rdiv_start)
        begin
            // Small-diff path waits for rate; decide at finish of divide.
        end
        if (div_done && !cmd.tdiv_take && !cmd.cdiv_take && upd_reg && rfire)
        begin
            acap_reg <= 1'b1;
            if (diff_reg != 0)
                diff_reg <= diff_reg[33] ? -capstep_reg : capstep_reg;
            else
                diff_reg <= lv_s > 0 ? -capstep_reg : capstep_reg;
        end
        if (cmd.fin)
        begin
            out_reg.new_rest_length      <= slewing_reg ? rnew[30:0] : rest_reg[30:0];
            out_reg.new_preferred_length <= pref_reg[31:0];
            out_reg.status               <= status_reg;
            out_reg.tension_capped       <= tcap_reg;
            out_reg.accel_capped         <= acap_reg;
        end
    end

    // The first two divisions must not trigger the rate check.
    assign stat.div_done   = div_done;
    assign stat.need_rdiv  = allow && !big;
    assign stat.is_tension = is_tension;
    assign stat.is_slew    = is_slew;
    assign out_data        = out_reg;
endmodule

FILE: src/cable_rest_length_slew_servo.sv
// Top level of the cable rest-length slew servo: controller plus datapath.
// Depends on crlss_pkg, crlss_ctrl, crlss_dp.
//
//  channel | signals                       | direction
//  in      | in_valid, in_stall, in_data   | item beat in
//  out     | out_valid, out_stall, out_data| result beat out
//  cfg     | cfg_write, cfg_index, cfg_data| register write
//
// One beat at a time. Direct, rejected and unused beats skip the divider; slew
// mode uses one or two passes of the 64-step shared divider and tension mode two
// or three, so up to three passes run per tick. Output stalls also delay
// acceptance of the next beat.
// Reset clears both lengths and loads register defaults.
// A result holds on out_data until taken; the next beat is accepted after.
`timescale 1ns / 1ps
module cable_rest_length_slew_servo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  crlss_pkg::in_beat_t   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output crlss_pkg::out_beat_t  out_data,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [30:0]           cfg_data
);
    import crlss_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    crlss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    crlss_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );
endmodule

FILE: sim/tb.sv
// Self-checking testbench for the cable rest-length slew servo.
// Drives item beats and register writes, predicts each result beat and checks it.
// Depends on crlss_pkg and cable_rest_length_slew_servo.
`timescale 1ns / 1ps
module tb;
    import crlss_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam longint MAX31 = 64'h7FFF_FFFF;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         in_valid = 1'b0;
    logic         in_stall;
    in_beat_t     in_data = '0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    out_beat_t    out_data;
    logic         cfg_write = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [30:0]  cfg_data = '0;

    // Predictor copy of registers and state.
    longint velocity_limit, accel_limit, tension_limit, short_floor, rest_floor;
    longint spring_k, tick_dt;
    longint rest_len, pref_len;

    out_beat_t servo_results[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  idle_enable = 1'b1;

    cable_rest_length_slew_servo dut (.*);

    always #5 clk = ~clk;

    function automatic longint sat_s32(longint x);
        if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (x < -64'sh8000_0000) return -64'sh8000_0000;
        return x;
    endfunction

    function automatic longint mag(longint x);
        return x < 0 ? -x : x;
    endfunction

    // Move the rest length toward the preferred length for one tick.
    function automatic void slew_rest(longint meas, longint lv, ref bit tcap, ref bit acap);
        longint dt, k, step, vchg, capstep, tmax, diff, s, rate;
        dt = tick_dt == 0 ? 1 : tick_dt;
        k = spring_k == 0 ? 1 : spring_k;
        step = (velocity_limit * dt) >>> 16;
        vchg = (accel_limit * dt) >>> 16;
        capstep = (vchg * dt) >>> 16;
        tmax = tension_limit * 65536;
        if ((meas - pref_len) * k > tmax)
        begin
            pref_len = sat_s32(meas - tmax / k);
            tcap = 1'b1;
        end
        diff = pref_len - rest_len;
        if (meas > short_floor || diff > 0)
        begin
            s = diff < 0 ? -1 : 1;
            if (mag(diff) > step)
            begin
                if (mag(s * velocity_limit - lv) > vchg)
                begin
                    step = capstep;
                    acap = 1'b1;
                end
                rest_len += s * step;
            end
            else
            begin
                rate = (diff * 65536) / dt;
                if (mag(rate - lv) > vchg)
                begin
                    acap = 1'b1;
                    if (diff != 0)
                        diff = s * capstep;
                    else
                        diff = (lv > 0 ? -1 : 1) * capstep;
                end
                rest_len += diff;
            end
        end
        if (rest_len < rest_floor) rest_len = rest_floor;
        if (rest_len > MAX31) rest_len = MAX31;
    endfunction

    function automatic out_beat_t servo_tick(in_beat_t b);
        out_beat_t r;
        longint cmd, meas, tens, lv, d, nl, k;
        bit st, tcap, acap;
        cmd = longint'(b.command_value);
        meas = longint'({1'b0, b.measured_length});
        tens = longint'(b.measured_tension);
        lv = longint'(b.last_velocity);
        st = 0; tcap = 0; acap = 0;
        k = spring_k == 0 ? 1 : spring_k;
        case (b.mode)
            MODE_SLEW:
                if (cmd < 0) st = 1;
                else
                begin
                    pref_len = cmd;
                    slew_rest(meas, lv, tcap, acap);
                end
            MODE_TENSION:
            begin
                d = ((cmd - tens) * 65536) / k;
                nl = rest_len - d;
                if (nl < rest_floor) nl = rest_floor;
                pref_len = sat_s32(nl);
                slew_rest(meas, lv, tcap, acap);
            end
            MODE_DIRECT:
                if (cmd < 0) st = 1;
                else
                begin
                    rest_len = cmd;
                    pref_len = cmd;
                end
            default: ;
        endcase
        r.new_rest_length = rest_len[30:0];
        r.new_preferred_length = pref_len[31:0];
        r.status = st;
        r.tension_capped = tcap;
        r.accel_capped = acap;
        return r;
    endfunction

    task automatic random_gap();
        if (idle_enable && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 9)) @(negedge clk);
    endtask

    // Send one item beat and record its expected result.
    task automatic send_beat(in_beat_t b);
        random_gap();
        @(negedge clk);
        in_data <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        servo_results.insert(servo_results.size(), servo_tick(b));
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (servo_results.size() != 0) @(negedge clk);
        repeat (250) @(negedge clk);
    endtask

    // Register write; called only while the block is idle.
    task automatic write_reg(logic [2:0] idx, longint val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[30:0];
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_TARGET_VELOCITY:  velocity_limit = val & MAX31;
            REG_MAX_ACCELERATION: accel_limit = val & MAX31;
            REG_MAX_TENSION:      tension_limit = val & MAX31;
            REG_MIN_CABLE_LENGTH: short_floor = val & MAX31;
            REG_MIN_REST_LENGTH:  rest_floor = val & MAX31;
            REG_STIFFNESS:        spring_k = val & MAX31;
            REG_TIME_STEP:        tick_dt = val & 64'hFFFF;
            default: ;
        endcase
        @(negedge clk);
    endtask

    function automatic in_beat_t make_beat(logic [1:0] m, longint c, longint ml,
                                           longint t, longint v);
        in_beat_t b;
        b.mode = m;
        b.command_value = c[31:0];
        b.measured_length = ml[30:0];
        b.measured_tension = t[31:0];
        b.last_velocity = v[31:0];
        return b;
    endfunction

    function automatic longint rand_len();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 32'h0010_0000);
            1: return $urandom & MAX31;
            2: return MAX31 - $urandom_range(0, 1000);
            default: return $urandom_range(0, 32'h0400_0000);
        endcase
    endfunction

    function automatic longint rand_s32();
        if ($urandom_range(0, 1)) return longint'(signed'($urandom));
        return longint'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endfunction

    function automatic in_beat_t rand_beat();
        logic [1:0] m;
        longint c;
        m = $urandom_range(0, 9) == 0 ? MODE_UNUSED : 2'($urandom_range(0, 2));
        c = (m == MODE_TENSION || $urandom_range(0, 7) == 0) ? rand_s32() : rand_len();
        return make_beat(m, c, rand_len(), rand_s32(), rand_s32());
    endfunction

    task automatic test_directed();
        write_reg(REG_TARGET_VELOCITY, 32'h0010_0000);
        write_reg(REG_MAX_ACCELERATION, 32'h0004_0000);
        send_beat(make_beat(MODE_DIRECT, 32'h0005_0000, 32'h0005_0000, 0, 0));
        send_beat(make_beat(MODE_SLEW, 32'h0009_0000, 32'h0005_0000, 0, 0));
        send_beat(make_beat(MODE_SLEW, 32'h0009_0000, 32'h0005_0000, 0, 32'h0010_0000));
        send_beat(make_beat(MODE_SLEW, 0, 32'h0005_0000, 0, 0));
        send_beat(make_beat(MODE_SLEW, -1, 0, 0, 0));
        send_beat(make_beat(MODE_DIRECT, -64'sh8000_0000, 0, 0, 0));
        send_beat(make_beat(MODE_DIRECT, MAX31, MAX31, 0, 0));
        send_beat(make_beat(MODE_SLEW, MAX31, MAX31, -64'sh8000_0000, 64'sh7FFF_FFFF));
        send_beat(make_beat(MODE_TENSION, 64'sh7FFF_FFFF, 0, -64'sh8000_0000, 0));
        send_beat(make_beat(MODE_TENSION, -64'sh8000_0000, MAX31, 64'sh7FFF_FFFF, 0));
        send_beat(make_beat(MODE_UNUSED, -1, MAX31, -1, -1));
        // Zero motion with the acceleration cap firing, both velocity signs.
        send_beat(make_beat(MODE_DIRECT, 32'h0003_0000, 32'h0003_0000, 0, 0));
        send_beat(make_beat(MODE_SLEW, 32'h0003_0000, 32'h0004_0000, 0, 32'h0100_0000));
        send_beat(make_beat(MODE_SLEW, 32'h0003_0000, 32'h0004_0000, 0, -32'sh0100_0000));
        drain();
        // Tension cap and shortening floor, then zero step and zero stiffness.
        write_reg(REG_MAX_TENSION, 32'h0001_0000);
        write_reg(REG_MIN_CABLE_LENGTH, 32'h0008_0000);
        write_reg(REG_MIN_REST_LENGTH, 32'h0002_0000);
        send_beat(make_beat(MODE_SLEW, 0, 32'h0010_0000, 0, 0));
        send_beat(make_beat(MODE_SLEW, 0, 32'h0004_0000, 0, 0));
        drain();
        write_reg(REG_TIME_STEP, 0);
        write_reg(REG_STIFFNESS, 0);
        send_beat(make_beat(MODE_TENSION, 32'h0001_0000, 32'h0004_0000, 0, 0));
        send_beat(make_beat(MODE_SLEW, 32'h0001_0000, 32'h0000_0000, 0, 0));
        drain();
    endtask

    // Random phases over several register settings, extremes included.
    task automatic test_random();
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_TARGET_VELOCITY, ph == 0 ? 0 : ph == 1 ? MAX31 : rand_len());
            write_reg(REG_MAX_ACCELERATION, ph == 0 ? MAX31 : ph == 1 ? 0 : rand_len());
            write_reg(REG_MAX_TENSION, ph == 2 ? 0 : ph == 3 ? MAX31 : rand_len());
            write_reg(REG_MIN_CABLE_LENGTH, ph == 4 ? MAX31 : $urandom_range(0, 32'h0010_0000));
            write_reg(REG_MIN_REST_LENGTH, ph == 1 ? MAX31 : $urandom_range(0, 32'h0008_0000));
            write_reg(REG_STIFFNESS, ph == 2 ? 1 : ph == 3 ? MAX31 : $urandom_range(1, 32'h0040_0000));
            write_reg(REG_TIME_STEP, ph == 0 ? 1 : ph == 1 ? 16'hFFFF : $urandom_range(1, 65535));
            if (ph == 5) idle_enable = 1'b0;
            for (int i = 0; i < 72; i++)
            begin
                send_beat(rand_beat());
                if (ph == 3 && i == 30)
                    while (servo_results.size() != 0) @(negedge clk);
            end
            drain();
        end
    endtask

    // Receiver stall bursts.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (servo_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result beat %h", out_data);
            end
            else
            begin
                out_beat_t e;
                e = servo_results.pop_front();
                if (e !== out_data)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected rest %h pref %h st %b tc %b ac %b, got rest %h pref %h st %b tc %b ac %b",
                                 e.new_rest_length, e.new_preferred_length, e.status,
                                 e.tension_capped, e.accel_capped,
                                 out_data.new_rest_length, out_data.new_preferred_length,
                                 out_data.status, out_data.tension_capped, out_data.accel_capped);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat, taken result or register write.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        velocity_limit = 0; accel_limit = 0; tension_limit = MAX31;
        short_floor = 0; rest_floor = 0; spring_k = 65536; tick_dt = 655;
        rest_len = 0; pref_len = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (300) @(negedge clk);
        test_directed();
        test_random();
        if (mismatches == 0 && servo_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: filelist.f
src/crlss_pkg.sv
src/crlss_div.sv
src/crlss_ctrl.sv
src/crlss_dp.sv
src/cable_rest_length_slew_servo.sv
sim/tb.sv
